// ===== sv/tsc_pkg.sv =====
// Shared types and constants for the touch swipe classifier.
// Used by tsc_ctrl, tsc_dp and touch_swipe_classifier_top; no dependencies.
package tsc_pkg;

    localparam int COORD_W    = 10;
    localparam int DELTA_W    = 11;
    localparam int TICK_W     = 32;
    localparam int WIDE_CFG_W = 16;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = WIDE_CFG_W + TICK_W;
    localparam int NUM_W      = 20;        // 1023 * 1000 fits in 20 bits
    localparam int DIV_STEPS  = 10;        // quotient below 1000 needs 10 bits

    localparam logic [COORD_W-1:0] PERMILLE_MAX = 10'd1000;
    localparam logic [COUNT_W-1:0] SAMPLE_MAX   = 16'hFFFF;

    // reset values of the configuration registers
    localparam logic [COORD_W-1:0]    RST_EDGE_MIN_DX      = 10'd64;
    localparam logic [COORD_W-1:0]    RST_CENTER_MIN_DX    = 10'd80;
    localparam logic [COORD_W-1:0]    RST_MAX_VERTICAL     = 10'd54;
    localparam logic [WIDE_CFG_W-1:0] RST_MAX_DURATION_MS  = 16'd900;
    localparam logic [WIDE_CFG_W-1:0] RST_EDGE_MIN_SPEED   = 16'd120;
    localparam logic [WIDE_CFG_W-1:0] RST_CENTER_MIN_SPEED = 16'd140;
    localparam logic [WIDE_CFG_W-1:0] RST_DRIFT_DURATION   = 16'd600;
    localparam logic [COORD_W-1:0]    RST_DRIFT_MIN_DX     = 10'd160;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNDEF   = 2'd3
    } op_t;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_MIN_DX      = 3'd0,
        REG_CENTER_MIN_DX    = 3'd1,
        REG_MAX_VERTICAL     = 3'd2,
        REG_MAX_DURATION_MS  = 3'd3,
        REG_EDGE_MIN_SPEED   = 3'd4,
        REG_CENTER_MIN_SPEED = 3'd5,
        REG_DRIFT_DURATION   = 3'd6,
        REG_DRIFT_MIN_DX     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic load;       // capture the input word
        logic update;     // apply press/move/release to gesture state
        logic prep;       // deltas, edge, duration
        logic mul_init;   // speed product and divider setup
        logic div_step;   // one quotient bit
        logic out_load;   // fill output register
    } dp_cmd_t;

    typedef struct packed {
        logic skip;       // item leaves state alone, result is zero apart from tracking
    } dp_status_t;

endpackage

// ===== sv/tsc_ctrl.sv =====
// Sequencer for the touch swipe classifier: steps one word through update, prep,
// multiply, divide and output load (a skipped word: update, then output load). Depends on tsc_pkg.
module tsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tsc_pkg::dp_status_t  status,
    output tsc_pkg::dp_cmd_t     cmd
);
    import tsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.skip ? S_FIN : S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/tsc_dp.sv =====
// Datapath for the touch swipe classifier: config registers, gesture state,
// speed product, restoring divider for progress and the output register.
// Depends on tsc_pkg; driven by tsc_ctrl commands.
module tsc_dp #(
    parameter int SCREEN_WIDTH = 640,
    parameter int EDGE_ZONE    = 96
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tsc_pkg::dp_cmd_t                        cmd,
    output tsc_pkg::dp_status_t                     status,
    input  logic                                    cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tsc_pkg::WIDE_CFG_W-1:0]          cfg_data,
    input  logic [1:0]                              operation,
    input  logic [tsc_pkg::COORD_W-1:0]             touch_x,
    input  logic [tsc_pkg::COORD_W-1:0]             touch_y,
    input  logic [tsc_pkg::TICK_W-1:0]              tick_ms,
    output logic                                    tracking,
    output logic                                    decided,
    output logic [1:0]                              direction,
    output logic [tsc_pkg::COORD_W-1:0]             progress_permille,
    output logic signed [tsc_pkg::DELTA_W-1:0]      delta_x,
    output logic signed [tsc_pkg::DELTA_W-1:0]      delta_y,
    output logic                                    from_edge,
    output logic [tsc_pkg::TICK_W-1:0]              duration_ms,
    output logic [tsc_pkg::COUNT_W-1:0]             sample_count
);
    import tsc_pkg::*;

    localparam int LEFT_EDGE = SCREEN_WIDTH - EDGE_ZONE;

    // configuration
    logic [COORD_W-1:0]    edge_min_dx_reg, center_min_dx_reg, max_vertical_reg;
    logic [COORD_W-1:0]    drift_min_dx_reg;
    logic [WIDE_CFG_W-1:0] max_duration_reg, edge_min_speed_reg, center_min_speed_reg;
    logic [WIDE_CFG_W-1:0] drift_duration_reg;

    // captured word
    op_t                op_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic               was_reg;

    // gesture state
    logic               active_reg;
    logic [COORD_W-1:0] start_x_reg, start_y_reg, latest_x_reg, lowest_y_reg, highest_y_reg;
    logic [TICK_W-1:0]  start_tick_reg;
    logic [COUNT_W-1:0] samples_reg;

    // derived values
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic [COORD_W-1:0]        adx_reg, ady_reg, spread_reg;
    logic                      edge_reg;
    logic [TICK_W-1:0]         dur_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [COORD_W-1:0]        rem_reg, nlo_reg, quo_reg;

    logic                      skip;
    logic signed [DELTA_W-1:0] dx_c, dy_c;
    logic [DELTA_W-1:0]        ndx_c, ndy_c;
    logic                      edge_c;
    logic [NUM_W-1:0]          num_c;
    logic [WIDE_CFG_W-1:0]     speed_floor_c;
    logic [COORD_W:0]          trial_c;
    logic                      fits_c;
    logic [COORD_W-1:0]        perm_c, min_dx_c;
    logic                      ok_c, timing_fail_c, is_rel_c;
    logic [1:0]                dir_c;

    assign skip        = (op_reg == OP_UNDEF) || ((op_reg != OP_PRESS) && !was_reg);
    assign status.skip = skip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_min_dx_reg      <= RST_EDGE_MIN_DX;
            center_min_dx_reg    <= RST_CENTER_MIN_DX;
            max_vertical_reg     <= RST_MAX_VERTICAL;
            max_duration_reg     <= RST_MAX_DURATION_MS;
            edge_min_speed_reg   <= RST_EDGE_MIN_SPEED;
            center_min_speed_reg <= RST_CENTER_MIN_SPEED;
            drift_duration_reg   <= RST_DRIFT_DURATION;
            drift_min_dx_reg     <= RST_DRIFT_MIN_DX;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_EDGE_MIN_DX:      edge_min_dx_reg      <= cfg_data[COORD_W-1:0];
                REG_CENTER_MIN_DX:    center_min_dx_reg    <= cfg_data[COORD_W-1:0];
                REG_MAX_VERTICAL:     max_vertical_reg     <= cfg_data[COORD_W-1:0];
                REG_MAX_DURATION_MS:  max_duration_reg     <= cfg_data;
                REG_EDGE_MIN_SPEED:   edge_min_speed_reg   <= cfg_data;
                REG_CENTER_MIN_SPEED: center_min_speed_reg <= cfg_data;
                REG_DRIFT_DURATION:   drift_duration_reg   <= cfg_data;
                REG_DRIFT_MIN_DX:     drift_min_dx_reg     <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(operation);
            x_reg    <= touch_x;
            y_reg    <= touch_y;
            tick_reg <= tick_ms;
            was_reg  <= active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            latest_x_reg   <= '0;
            lowest_y_reg   <= '0;
            highest_y_reg  <= '0;
            start_tick_reg <= '0;
            samples_reg    <= '0;
        end
        else if (cmd.update && !skip)
        begin
            if (op_reg == OP_PRESS)
            begin
                active_reg     <= 1'b1;
                start_x_reg    <= x_reg;
                start_y_reg    <= y_reg;
                latest_x_reg   <= x_reg;
                lowest_y_reg   <= y_reg;
                highest_y_reg  <= y_reg;
                start_tick_reg <= tick_reg;
                samples_reg    <= COUNT_W'(1);
            end
            else
            begin
                latest_x_reg <= x_reg;
                if (y_reg < lowest_y_reg)
                    lowest_y_reg <= y_reg;
                if (y_reg > highest_y_reg)
                    highest_y_reg <= y_reg;
                if (samples_reg != SAMPLE_MAX)
                    samples_reg <= samples_reg + 1'b1;
                if (op_reg == OP_RELEASE)
                    active_reg <= 1'b0;
            end
        end
    end

    // deltas and edge zone test
    always_comb
    begin
        dx_c  = $signed({1'b0, latest_x_reg}) - $signed({1'b0, start_x_reg});
        dy_c  = $signed({1'b0, y_reg}) - $signed({1'b0, start_y_reg});
        ndx_c = -dx_c;
        ndy_c = -dy_c;
        if (dx_c < 0)
            edge_c = (LEFT_EDGE <= 0) || ({1'b0, start_x_reg} >= DELTA_W'(LEFT_EDGE));
        else if (dx_c > 0)
            edge_c = ({1'b0, start_x_reg} <= DELTA_W'(EDGE_ZONE));
        else
            edge_c = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            dx_reg     <= dx_c;
            dy_reg     <= dy_c;
            adx_reg    <= dx_c[DELTA_W-1] ? ndx_c[COORD_W-1:0] : dx_c[COORD_W-1:0];
            ady_reg    <= dy_c[DELTA_W-1] ? ndy_c[COORD_W-1:0] : dy_c[COORD_W-1:0];
            edge_reg   <= edge_c;
            spread_reg <= highest_y_reg - lowest_y_reg;
            dur_reg    <= tick_reg - start_tick_reg;
        end
    end

    // adx*1000 < min_speed*dur is the same test as floor(adx*1000/dur) < min_speed
    assign num_c         = NUM_W'(adx_reg) * NUM_W'(PERMILLE_MAX);
    assign speed_floor_c = edge_reg ? edge_min_speed_reg : center_min_speed_reg;
    assign trial_c       = {rem_reg, nlo_reg[COORD_W-1]};
    assign fits_c        = (trial_c >= {1'b0, edge_min_dx_reg});

    // restoring divider; only used when adx < edge_min_dx so the top
    // half of the numerator is already below the divisor
    always_ff @(posedge clk)
    begin
        if (cmd.mul_init)
        begin
            prod_reg <= PROD_W'(speed_floor_c) * PROD_W'(dur_reg);
            num_reg  <= num_c;
            rem_reg  <= num_c[NUM_W-1:NUM_W-COORD_W];
            nlo_reg  <= num_c[COORD_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits_c ? COORD_W'(trial_c - {1'b0, edge_min_dx_reg})
                              : trial_c[COORD_W-1:0];
            nlo_reg <= {nlo_reg[COORD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[COORD_W-2:0], fits_c};
        end
    end

    // classification
    always_comb
    begin
        is_rel_c = (op_reg == OP_RELEASE);

        if (edge_min_dx_reg == '0)
            perm_c = (adx_reg != '0) ? PERMILLE_MAX : '0;
        else if (adx_reg >= edge_min_dx_reg)
            perm_c = PERMILLE_MAX;
        else
            perm_c = quo_reg;

        min_dx_c      = edge_reg ? edge_min_dx_reg : center_min_dx_reg;
        timing_fail_c = (dur_reg > TICK_W'(max_duration_reg))
                     || (PROD_W'(num_reg) < prod_reg)
                     || ((dur_reg > TICK_W'(drift_duration_reg))
                         && (adx_reg < drift_min_dx_reg));
        ok_c = !((adx_reg < min_dx_c) || (ady_reg > max_vertical_reg)
                 || (spread_reg > max_vertical_reg))
               && !((dur_reg != '0) && timing_fail_c);

        if (is_rel_c)
            dir_c = ok_c ? (dx_reg[DELTA_W-1] ? DIR_LEFT : DIR_RIGHT) : DIR_NONE;
        else if (dx_reg[DELTA_W-1])
            dir_c = DIR_LEFT;
        else if (dx_reg != '0)
            dir_c = DIR_RIGHT;
        else
            dir_c = DIR_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            tracking <= was_reg;
            if (skip)
            begin
                decided           <= 1'b0;
                direction         <= DIR_NONE;
                progress_permille <= '0;
                delta_x           <= '0;
                delta_y           <= '0;
                from_edge         <= 1'b0;
                duration_ms       <= '0;
                sample_count      <= '0;
            end
            else
            begin
                decided           <= is_rel_c;
                direction         <= dir_c;
                progress_permille <= perm_c;
                delta_x           <= dx_reg;
                delta_y           <= is_rel_c ? dy_reg : '0;
                from_edge         <= edge_reg;
                duration_ms       <= is_rel_c ? dur_reg : '0;
                sample_count      <= samples_reg;
            end
        end
    end

endmodule

// ===== sv/touch_swipe_classifier_top.sv =====
// Touch swipe classifier: press/move/release words in, one result word out.
// One word in flight: in_stall holds off new words while each one goes through update,
// prep, multiply, the 10-step progress divider and output load (an ignored word goes
// from update to output load). Output register frees the input side early.
// Reset (rst_n, async): idle, no gesture, config registers at defaults.
module touch_swipe_classifier_top #(
    parameter int SCREEN_WIDTH = 640,
    parameter int EDGE_ZONE    = 96
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              operation,
    input  logic [tsc_pkg::COORD_W-1:0]             touch_x,
    input  logic [tsc_pkg::COORD_W-1:0]             touch_y,
    input  logic [tsc_pkg::TICK_W-1:0]              tick_ms,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    tracking,
    output logic                                    decided,
    output logic [1:0]                              direction,
    output logic [tsc_pkg::COORD_W-1:0]             progress_permille,
    output logic signed [tsc_pkg::DELTA_W-1:0]      delta_x,
    output logic signed [tsc_pkg::DELTA_W-1:0]      delta_y,
    output logic                                    from_edge,
    output logic [tsc_pkg::TICK_W-1:0]              duration_ms,
    output logic [tsc_pkg::COUNT_W-1:0]             sample_count,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tsc_pkg::WIDE_CFG_W-1:0]          cfg_data
);
    import tsc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tsc_dp #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .EDGE_ZONE    (EDGE_ZONE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .touch_x           (touch_x),
        .touch_y           (touch_y),
        .tick_ms           (tick_ms),
        .tracking          (tracking),
        .decided           (decided),
        .direction         (direction),
        .progress_permille (progress_permille),
        .delta_x           (delta_x),
        .delta_y           (delta_y),
        .from_edge         (from_edge),
        .duration_ms       (duration_ms),
        .sample_count      (sample_count)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for touch_swipe_classifier_top: press/move/release words with a
// gesture tracker in the bench that predicts every result word.
// Depends on tsc_pkg and the classifier RTL.
module testbench;
    import tsc_pkg::*;

    localparam int SCREEN_W     = 640;
    localparam int EDGE_W       = 96;
    localparam int RANDOM_WORDS = 950;
    localparam int PHASE_WORDS  = 190;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic               tracking;
        logic               decided;
        logic [1:0]         direction;
        logic [COORD_W-1:0] progress;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        logic               at_edge;
        logic [TICK_W-1:0]  duration;
        logic [COUNT_W-1:0] samples;
    } swipe_word_t;

    typedef enum int {SET_DEFAULT, SET_ZERO, SET_MAX, SET_RANDOM} setting_t;
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             operation = '0;
    logic [COORD_W-1:0]     touch_x = '0;
    logic [COORD_W-1:0]     touch_y = '0;
    logic [TICK_W-1:0]      tick_ms = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   tracking;
    logic                   decided;
    logic [1:0]             direction;
    logic [COORD_W-1:0]     progress_permille;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                   from_edge;
    logic [TICK_W-1:0]      duration_ms;
    logic [COUNT_W-1:0]     sample_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WIDE_CFG_W-1:0]  cfg_data = '0;

    // gesture tracker and register copy used for prediction
    logic                   trk_active;
    logic [COORD_W-1:0]     trk_start_x;
    logic [COORD_W-1:0]     trk_start_y;
    logic [COORD_W-1:0]     trk_last_x;
    logic [COORD_W-1:0]     trk_low_y;
    logic [COORD_W-1:0]     trk_high_y;
    logic [TICK_W-1:0]      trk_start_tick;
    logic [COUNT_W-1:0]     trk_samples;
    logic [WIDE_CFG_W-1:0]  cfg_shadow [8];

    swipe_word_t            pending_results [$];
    int                     mismatches = 0;
    int                     words_sent = 0;
    int                     burst_left = 0;
    stall_mode_t            stall_mode = STALL_NONE;
    int                     stall_left = 0;
    int                     stall_period = 2;
    int                     stall_phase = 0;

    touch_swipe_classifier_top #(
        .SCREEN_WIDTH(SCREEN_W),
        .EDGE_ZONE   (EDGE_W)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .touch_x          (touch_x),
        .touch_y          (touch_y),
        .tick_ms          (tick_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .tracking         (tracking),
        .decided          (decided),
        .direction        (direction),
        .progress_permille(progress_permille),
        .delta_x          (delta_x),
        .delta_y          (delta_y),
        .from_edge        (from_edge),
        .duration_ms      (duration_ms),
        .sample_count     (sample_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic bit is_narrow(reg_idx_t idx);
        return idx == REG_EDGE_MIN_DX || idx == REG_CENTER_MIN_DX ||
               idx == REG_MAX_VERTICAL || idx == REG_DRIFT_MIN_DX;
    endfunction

    function automatic int reset_value(reg_idx_t idx);
        case (idx)
            REG_EDGE_MIN_DX:      return RST_EDGE_MIN_DX;
            REG_CENTER_MIN_DX:    return RST_CENTER_MIN_DX;
            REG_MAX_VERTICAL:     return RST_MAX_VERTICAL;
            REG_MAX_DURATION_MS:  return RST_MAX_DURATION_MS;
            REG_EDGE_MIN_SPEED:   return RST_EDGE_MIN_SPEED;
            REG_CENTER_MIN_SPEED: return RST_CENTER_MIN_SPEED;
            REG_DRIFT_DURATION:   return RST_DRIFT_DURATION;
            default:              return RST_DRIFT_MIN_DX;
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    function automatic string word_text(swipe_word_t w);
        return $sformatf({"trk=%0b dec=%0b dir=%0d prog=%0d dx=%0d dy=%0d",
                          " edge=%0b dur=%0d cnt=%0d"},
                         w.tracking, w.decided, w.direction, w.progress, $signed(w.dx),
                         $signed(w.dy), w.at_edge, w.duration, w.samples);
    endfunction

    // Applies one touch word to the tracker and returns the result it should produce.
    function automatic swipe_word_t classify_touch(op_t op, logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y,
                                                   logic [TICK_W-1:0] tick);
        swipe_word_t       r;
        int                dx;
        int                dy;
        int                adx;
        int                ady;
        int                spread;
        int                min_dx;
        int                p;
        longint unsigned   speed;
        logic [TICK_W-1:0] dur;
        logic [15:0]       speed_floor;
        bit                ok;
        bit                at_edge;
        r = '0;
        r.tracking = trk_active;
        if (op == OP_UNDEF || (op != OP_PRESS && !trk_active))
            return r;
        if (op == OP_PRESS)
        begin
            trk_active     = 1'b1;
            trk_start_x    = x;
            trk_start_y    = y;
            trk_last_x     = x;
            trk_low_y      = y;
            trk_high_y     = y;
            trk_start_tick = tick;
            trk_samples    = COUNT_W'(1);
        end
        else
        begin
            trk_last_x = x;
            if (y < trk_low_y)
                trk_low_y = y;
            if (y > trk_high_y)
                trk_high_y = y;
            if (trk_samples != SAMPLE_MAX)
                trk_samples = trk_samples + 1'b1;
        end

        dx  = int'(trk_last_x) - int'(trk_start_x);
        adx = (dx < 0) ? -dx : dx;
        if (dx < 0)
            at_edge = int'(trk_start_x) >= SCREEN_W - EDGE_W;
        else if (dx > 0)
            at_edge = int'(trk_start_x) <= EDGE_W;
        else
            at_edge = 1'b0;

        if (cfg_shadow[REG_EDGE_MIN_DX] == 0)
            p = (adx != 0) ? 1000 : 0;
        else
            p = adx * 1000 / int'(cfg_shadow[REG_EDGE_MIN_DX]);
        r.progress = (p >= 1000) ? PERMILLE_MAX : p[COORD_W-1:0];

        if (op == OP_RELEASE)
        begin
            dy     = int'(y) - int'(trk_start_y);
            ady    = (dy < 0) ? -dy : dy;
            spread = int'(trk_high_y) - int'(trk_low_y);
            dur    = tick - trk_start_tick;
            min_dx = at_edge ? int'(cfg_shadow[REG_EDGE_MIN_DX])
                             : int'(cfg_shadow[REG_CENTER_MIN_DX]);
            ok = !(adx < min_dx || ady > int'(cfg_shadow[REG_MAX_VERTICAL]) ||
                   spread > int'(cfg_shadow[REG_MAX_VERTICAL]));
            // zero duration skips the timing tests entirely
            if (ok && dur != 0)
            begin
                speed_floor = at_edge ? cfg_shadow[REG_EDGE_MIN_SPEED]
                                      : cfg_shadow[REG_CENTER_MIN_SPEED];
                speed = (64'(adx) * 64'd1000) / 64'(dur);
                if (dur > cfg_shadow[REG_MAX_DURATION_MS] || speed < speed_floor ||
                    (dur > cfg_shadow[REG_DRIFT_DURATION] &&
                     adx < int'(cfg_shadow[REG_DRIFT_MIN_DX])))
                    ok = 1'b0;
            end
            r.direction = ok ? ((dx < 0) ? DIR_LEFT : DIR_RIGHT) : DIR_NONE;
            r.decided   = 1'b1;
            r.dy        = dy[DELTA_W-1:0];
            r.duration  = dur;
            trk_active  = 1'b0;
        end
        else
            r.direction = (dx < 0) ? DIR_LEFT : ((dx > 0) ? DIR_RIGHT : DIR_NONE);

        r.dx      = dx[DELTA_W-1:0];
        r.at_edge = at_edge;
        r.samples = trk_samples;
        return r;
    endfunction

    // Sends one touch word in bursts with random gaps; predicts it once accepted.
    task automatic send_touch(op_t op, int x, int y, logic [TICK_W-1:0] tick);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        touch_x   <= x[COORD_W-1:0];
        touch_y   <= y[COORD_W-1:0];
        tick_ms   <= tick;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(classify_touch(op, x[COORD_W-1:0], y[COORD_W-1:0], tick));
        words_sent++;
    endtask

    // Stops sending and holds until every predicted word has come back.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(reg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[WIDE_CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_shadow[idx] = is_narrow(idx) ? WIDE_CFG_W'(value & 'h3FF)
                                         : WIDE_CFG_W'(value & 'hFFFF);
    endtask

    function automatic int pick_value(reg_idx_t idx, setting_t kind);
        int top;
        int base;
        top  = is_narrow(idx) ? 1023 : 65535;
        base = reset_value(idx);
        case (kind)
            SET_DEFAULT: return base;
            SET_ZERO:    return 0;
            SET_MAX:     return top;
            default:
                case ($urandom_range(0, 7))
                    0:       return 0;
                    1:       return top;
                    2:       return $urandom_range(0, top);
                    default: return $urandom_range(base / 2, (base * 2 > top) ? top : base * 2);
                endcase
        endcase
    endfunction

    task automatic apply_setting(setting_t kind);
        wait_results_done();
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), pick_value(reg_idx_t'(i), kind));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_words();
        send_touch(OP_MOVE, 1023, 1023, 32'hFFFF_FFFF);
        send_touch(OP_RELEASE, 0, 0, 32'h0);
        send_touch(OP_UNDEF, 512, 512, 32'hAAAA_AAAA);
    endtask

    task automatic test_gesture_cases();
        // wide travel but the y spread is far over the limit
        send_touch(OP_PRESS, 0, 0, 32'h0);
        send_touch(OP_MOVE, 1023, 1023, 32'h5555_5555);
        send_touch(OP_RELEASE, 1023, 0, 32'd40);
        // undefined op and a second press while a gesture is open
        send_touch(OP_PRESS, 1023, 1023, 32'hFFFF_FFFF);
        send_touch(OP_UNDEF, 0, 0, 32'h0);
        send_touch(OP_PRESS, 600, 500, 32'd100);
        send_touch(OP_RELEASE, 500, 505, 32'd100);
        // tick wraps between press and release
        send_touch(OP_PRESS, 50, 300, 32'hFFFF_FFF0);
        send_touch(OP_RELEASE, 200, 310, 32'h0000_0100);
        send_touch(OP_PRESS, 300, 300, 32'd10);
        send_touch(OP_RELEASE, 300, 300, 32'd20);
        // slow drift
        send_touch(OP_PRESS, 50, 200, 32'd1000);
        send_touch(OP_RELEASE, 150, 200, 32'd1700);
        send_touch(OP_PRESS, 500, 400, 32'd0);
        send_touch(OP_RELEASE, 300, 400, 32'd1000);
    endtask

    task automatic test_zero_thresholds();
        apply_setting(SET_ZERO);
        // no travel still passes a zero minimum and goes right
        send_touch(OP_PRESS, 700, 100, 32'd7);
        send_touch(OP_RELEASE, 700, 100, 32'd7);
        send_touch(OP_PRESS, 10, 10, 32'd0);
        send_touch(OP_RELEASE, 11, 10, 32'd1);
    endtask

    task automatic test_max_thresholds();
        apply_setting(SET_MAX);
        send_touch(OP_PRESS, 0, 0, 32'd0);
        send_touch(OP_RELEASE, 1023, 1023, 32'd65535);
    endtask

    task automatic run_gesture();
        int                sx;
        int                sy;
        int                ex;
        int                travel;
        int                jitter;
        int                moves;
        int                roll;
        logic [TICK_W-1:0] t0;
        logic [TICK_W-1:0] dur;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            send_touch(op_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom);
            return;
        end
        case ($urandom_range(0, 3))
            0: sx = $urandom_range(0, EDGE_W);
            1: sx = $urandom_range(SCREEN_W - EDGE_W, SCREEN_W - 1);
            2: sx = $urandom_range(0, 1023);
            default: sx = ($urandom_range(0, 1) ? EDGE_W : SCREEN_W - EDGE_W) +
                          int'($urandom_range(0, 2)) - 1;
        endcase
        sy     = $urandom_range(0, 1023);
        travel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 250);
        ex     = clamp_coord($urandom_range(0, 1) ? sx + travel : sx - travel);
        jitter = ($urandom_range(0, 5) == 0) ? 200 : 30;
        moves  = $urandom_range(0, 5);
        t0     = $urandom;
        case ($urandom_range(0, 7))
            0:       dur = 0;
            1:       dur = $urandom;
            default: dur = $urandom_range(1, 1300);
        endcase
        send_touch(OP_PRESS, sx, sy, t0);
        for (int k = 1; k <= moves; k++)
            send_touch(OP_MOVE, sx + (ex - sx) * k / (moves + 1),
                       clamp_coord(sy + int'($urandom_range(0, 2 * jitter)) - jitter), $urandom);
        // an abandoned gesture leaves the next press to restart it
        if (roll != 1)
            send_touch(OP_RELEASE, ex,
                       clamp_coord(sy + int'($urandom_range(0, 2 * jitter)) - jitter), t0 + dur);
    endtask

    task automatic test_random_gestures();
        int target;
        int phase_start;
        target      = words_sent + RANDOM_WORDS;
        phase_start = words_sent;
        apply_setting(SET_DEFAULT);
        while (words_sent < target)
        begin
            if (words_sent - phase_start >= PHASE_WORDS)
            begin
                apply_setting(($urandom_range(0, 4) == 0) ? SET_DEFAULT : SET_RANDOM);
                phase_start = words_sent;
            end
            else if ($urandom_range(0, 40) == 0)
                wait_results_done();
            run_gesture();
        end
    endtask

    // receiver stalls: stretches of none, random or periodic
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode   = stall_mode_t'($urandom_range(0, 2));
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 7);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 1) == 1);
            default:      out_stall <= (stall_phase % stall_period) == 0;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        swipe_word_t got;
        swipe_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {tracking, decided, direction, progress_permille, delta_x, delta_y,
                   from_edge, duration_ms, sample_count};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: %s", word_text(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", word_text(want));
                        $display("  actual   %s", word_text(got));
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            cfg_shadow[i] = WIDE_CFG_W'(reset_value(reg_idx_t'(i)));
        trk_active     = 1'b0;
        trk_start_x    = '0;
        trk_start_y    = '0;
        trk_last_x     = '0;
        trk_low_y      = '0;
        trk_high_y     = '0;
        trk_start_tick = '0;
        trk_samples    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_words();
        test_gesture_cases();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_gestures();

        wait_results_done();
        repeat (20) @(posedge clk);
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tsc_pkg.sv
sv/tsc_ctrl.sv
sv/tsc_dp.sv
sv/touch_swipe_classifier_top.sv
test/testbench.sv
